// File: src/serial_led_preset_controller_core_macros.svh
// Assertion macros used by the core RTL file of the LED preset controller.
`ifndef SERIAL_LED_PRESET_CONTROLLER_CORE_MACROS_SVH
`define SERIAL_LED_PRESET_CONTROLLER_CORE_MACROS_SVH

// Implication in the same cycle, checked while out of reset.
`define SLPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle, checked while out of reset.
`define SLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/slpc_pkg.sv
// ----------------------------------------------------------------------------
// slpc_pkg
// Types, constants and helper functions of the serial LED preset controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slpc_pkg;

    localparam int DATA_W  = 8;
    localparam int LEVEL_W = 10;
    localparam int MSG_W   = 4;
    localparam int NUM_W   = 7;
    localparam int MODE_W  = 2;
    localparam int COLOR_W = 2;
    localparam int DUTY_W  = 7;

    localparam int SLOT_COUNT_DEFAULT = 9;

    // Command characters.
    localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [DATA_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CHAR_A     = 8'h61;
    localparam logic [DATA_W-1:0] CHAR_B     = 8'h62;
    localparam logic [DATA_W-1:0] CHAR_C     = 8'h63;
    localparam logic [DATA_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [DATA_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [DUTY_W-1:0]  DUTY_STEP   = 7'd10;
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 10'd100;

    // Colors.
    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd2;

    // Message codes.
    localparam logic [MSG_W-1:0] MSG_OFF        = 4'd0;
    localparam logic [MSG_W-1:0] MSG_PRESET     = 4'd1;
    localparam logic [MSG_W-1:0] MSG_CONFIG     = 4'd2;
    localparam logic [MSG_W-1:0] MSG_UNKNOWN    = 4'd3;
    localparam logic [MSG_W-1:0] MSG_PICK_COLOR = 4'd4;
    localparam logic [MSG_W-1:0] MSG_ADJUST     = 4'd5;
    localparam logic [MSG_W-1:0] MSG_BRIGHTNESS = 4'd6;
    localparam logic [MSG_W-1:0] MSG_SAVED      = 4'd7;
    localparam logic [MSG_W-1:0] MSG_INVALID    = 4'd8;

    // Mode codes as seen on the result word.
    localparam logic [MODE_W-1:0] MODE_CODE_WORK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_SLOT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_COLOR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_BRIGHT = 2'd3;

    typedef enum logic [3:0] {
        MODE_RUN    = 4'b0001,
        MODE_SLOT   = 4'b0010,
        MODE_COLOR  = 4'b0100,
        MODE_BRIGHT = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] yellow;
        logic [LEVEL_W-1:0] red;
    } levels_t;

    // Write request into the preset table.
    typedef struct packed {
        logic               color_we;
        logic               duty_we;
        logic [COLOR_W-1:0] color;
        logic [DUTY_W-1:0]  duty;
    } table_wr_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        case (m)
            MODE_RUN:    code = MODE_CODE_WORK;
            MODE_SLOT:   code = MODE_CODE_SLOT;
            MODE_COLOR:  code = MODE_CODE_COLOR;
            MODE_BRIGHT: code = MODE_CODE_BRIGHT;
            default:     code = MODE_CODE_WORK;
        endcase
        return code;
    endfunction

    // Factory presets: three slots per color at 10, 40 and 100 percent.
    function automatic logic [COLOR_W-1:0] reset_color(input logic [3:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            4'd0, 4'd1, 4'd2: c = COLOR_GREEN;
            4'd3, 4'd4, 4'd5: c = COLOR_YELLOW;
            default:          c = COLOR_RED;
        endcase
        return c;
    endfunction

    function automatic logic [DUTY_W-1:0] reset_duty(input logic [3:0] idx);
        logic [DUTY_W-1:0] d;
        case (idx)
            4'd0, 4'd3, 4'd6: d = 7'd10;
            4'd1, 4'd4, 4'd7: d = 7'd40;
            default:          d = 7'd100;
        endcase
        return d;
    endfunction

    // Clears all channels and lights the one of the given color at duty times ten.
    function automatic levels_t apply_preset(input logic [COLOR_W-1:0] color,
                                             input logic [DUTY_W-1:0] duty);
        levels_t            lv;
        logic [10:0]        scaled;
        logic [LEVEL_W-1:0] level;
        scaled = {1'b0, duty, 3'b000} + {3'b000, duty, 1'b0};
        if (scaled > {1'b0, LEVEL_MAX}) begin
            level = LEVEL_MAX;
        end else begin
            level = scaled[LEVEL_W-1:0];
        end
        lv = '0;
        case (color)
            COLOR_GREEN:  lv.green  = level;
            COLOR_YELLOW: lv.yellow = level;
            COLOR_RED:    lv.red    = level;
            default:      lv = '0;
        endcase
        return lv;
    endfunction

endpackage

`default_nettype wire

// File: src/slpc_preset_table.sv
// ----------------------------------------------------------------------------
// slpc_preset_table
// Preset storage: color and duty of each slot, one read and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slpc_preset_table #(
    parameter int SLOT_COUNT = slpc_pkg::SLOT_COUNT_DEFAULT,
    parameter int SLOT_W     = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [SLOT_W-1:0]           rd_idx,
    output      logic [slpc_pkg::COLOR_W-1:0] rd_color,
    output      logic [slpc_pkg::DUTY_W-1:0]  rd_duty,
    input  wire logic [SLOT_W-1:0]           wr_idx,
    input  wire slpc_pkg::table_wr_t         wr
);
    import slpc_pkg::*;

    logic [COLOR_W-1:0] color_reg [SLOT_COUNT];
    logic [DUTY_W-1:0]  duty_reg  [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                color_reg[i] <= reset_color(4'(i));
                duty_reg[i]  <= reset_duty(4'(i));
            end
        end else begin
            if (wr.color_we) begin
                color_reg[wr_idx] <= wr.color;
            end
            if (wr.duty_we) begin
                duty_reg[wr_idx] <= wr.duty;
            end
        end
    end

    // The index can exceed the slot count for a byte that is not a checked digit; the read data is then not used.
    assign rd_color = color_reg[rd_idx];
    assign rd_duty  = duty_reg[rd_idx];

endmodule

`default_nettype wire

// File: src/serial_led_preset_controller_core.sv
// ----------------------------------------------------------------------------
// serial_led_preset_controller_core
// Command interpreter for an LED preset controller: one command byte in,
// one word of channel levels, message code and mode out.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_rx_byte
//   m_        out        m_valid/m_ready    levels, message, number, mode_now
//
// One word per cycle sustained while the output is not stalled; a byte is taken
// into the input register when accepted and its result word then moves into the result register.
// The mode, preset table and channel levels update in the cycle that moves a
// word from the input register to the result register.
// A stalled output holds the result register; the input register still takes
// one more word. Reset restores the factory presets in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_led_preset_controller_core_macros.svh"

module serial_led_preset_controller_core #(
    parameter int SLOT_COUNT = slpc_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic [slpc_pkg::DATA_W-1:0]  s_rx_byte,
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic [slpc_pkg::LEVEL_W-1:0] m_green_level,
    output      logic [slpc_pkg::LEVEL_W-1:0] m_yellow_level,
    output      logic [slpc_pkg::LEVEL_W-1:0] m_red_level,
    output      logic [slpc_pkg::MSG_W-1:0]   m_message,
    output      logic [slpc_pkg::NUM_W-1:0]   m_number,
    output      logic [slpc_pkg::MODE_W-1:0]  m_mode_now
);
    import slpc_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Input register.
    logic              in_valid_reg;
    logic [DATA_W-1:0] rx_reg;

    // Controller state.
    mode_t             mode_reg, mode_next;
    levels_t           levels_reg, levels_next;
    logic [SLOT_W-1:0] editing_reg, editing_next;
    logic [SLOT_W-1:0] active_reg, active_next;

    // Result register.
    logic              out_valid_reg;
    levels_t           out_levels_reg;
    logic [MSG_W-1:0]  out_msg_reg, msg_next;
    logic [NUM_W-1:0]  out_num_reg, num_next;
    logic [MODE_W-1:0] out_mode_reg;

    logic              advance;
    logic              is_digit;
    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] rd_idx;
    logic [COLOR_W-1:0] rd_color;
    logic [DUTY_W-1:0]  rd_duty;
    logic [COLOR_W-1:0] new_color;
    logic [DUTY_W:0]    duty_up;
    logic [DUTY_W-1:0]  new_duty;
    table_wr_t          tbl_wr;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rx_reg <= s_rx_byte;
        end
    end

    slpc_preset_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_color (rd_color),
        .rd_duty  (rd_duty),
        .wr_idx   (editing_reg),
        .wr       (tbl_wr)
    );

    assign is_digit = ({1'b0, rx_reg} >= {1'b0, CHAR_ONE}) &&
                      ({1'b0, rx_reg} < ({1'b0, CHAR_ONE} + 9'(SLOT_COUNT)));
    assign slot_idx = SLOT_W'(rx_reg - CHAR_ONE);
    assign rd_idx   = (mode_reg == MODE_RUN || mode_reg == MODE_SLOT) ? slot_idx
                                                                     : editing_reg;
    assign new_color = COLOR_W'(rx_reg - CHAR_A);

    // Duty steps saturate at zero and full scale.
    assign duty_up = {1'b0, rd_duty} + {1'b0, DUTY_STEP};
    always_comb begin
        if (rx_reg == CHAR_PLUS) begin
            new_duty = (duty_up > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_up[DUTY_W-1:0];
        end else begin
            new_duty = (rd_duty < DUTY_STEP) ? '0 : rd_duty - DUTY_STEP;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        levels_next  = levels_reg;
        editing_next = editing_reg;
        active_next  = active_reg;
        msg_next     = MSG_INVALID;
        num_next     = '0;
        tbl_wr       = '0;
        case (mode_reg)
            MODE_RUN: begin
                if (rx_reg == CHAR_ZERO) begin
                    levels_next = '0;
                    msg_next    = MSG_OFF;
                end else if (is_digit) begin
                    active_next = slot_idx;
                    levels_next = apply_preset(rd_color, rd_duty);
                    msg_next    = MSG_PRESET;
                    num_next    = NUM_W'(slot_idx) + NUM_W'(1);
                end else if (rx_reg == CHAR_CR) begin
                    mode_next = MODE_SLOT;
                    msg_next  = MSG_CONFIG;
                end else begin
                    msg_next = MSG_UNKNOWN;
                end
            end
            MODE_SLOT: begin
                if (is_digit) begin
                    editing_next = slot_idx;
                    levels_next  = apply_preset(rd_color, rd_duty);
                    mode_next    = MODE_COLOR;
                    msg_next     = MSG_PICK_COLOR;
                end else if (rx_reg == CHAR_CR) begin
                    mode_next = MODE_RUN;
                    msg_next  = MSG_SAVED;
                end
            end
            MODE_COLOR: begin
                if (rx_reg == CHAR_A || rx_reg == CHAR_B || rx_reg == CHAR_C) begin
                    tbl_wr.color_we = 1'b1;
                    tbl_wr.color    = new_color;
                    levels_next     = apply_preset(new_color, rd_duty);
                    mode_next       = MODE_BRIGHT;
                    msg_next        = MSG_ADJUST;
                end else if (rx_reg == CHAR_CR) begin
                    mode_next = MODE_RUN;
                    msg_next  = MSG_SAVED;
                end
            end
            MODE_BRIGHT: begin
                if (rx_reg == CHAR_PLUS || rx_reg == CHAR_MINUS) begin
                    tbl_wr.duty_we = 1'b1;
                    tbl_wr.duty    = new_duty;
                    levels_next    = apply_preset(rd_color, new_duty);
                    msg_next       = MSG_BRIGHTNESS;
                    num_next       = new_duty;
                end else if (rx_reg == CHAR_CR) begin
                    mode_next = MODE_RUN;
                    msg_next  = MSG_SAVED;
                end
            end
            default: begin
                mode_next = MODE_RUN;
            end
        endcase
        if (!advance) begin
            tbl_wr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_RUN;
            levels_reg.green  <= LEVEL_RESET;
            levels_reg.yellow <= '0;
            levels_reg.red    <= '0;
            editing_reg       <= '0;
            active_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg    <= mode_next;
                levels_reg  <= levels_next;
                editing_reg <= editing_next;
                active_reg  <= active_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_levels_reg <= levels_next;
            out_msg_reg    <= msg_next;
            out_num_reg    <= num_next;
            out_mode_reg   <= mode_code(mode_next);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_green_level  = out_levels_reg.green;
    assign m_yellow_level = out_levels_reg.yellow;
    assign m_red_level    = out_levels_reg.red;
    assign m_message      = out_msg_reg;
    assign m_number       = out_num_reg;
    assign m_mode_now     = out_mode_reg;

    // At most one channel is ever lit.
    `SLPC_ASSERT_SAME(a_one_lit, aclk, aresetn, m_valid,
        $countones({m_green_level != '0, m_yellow_level != '0, m_red_level != '0}) <= 1)
    // A preset message carries the slot that was just made active.
    `SLPC_ASSERT_SAME(a_preset_slot, aclk, aresetn, m_valid && m_message == MSG_PRESET,
        m_number == NUM_W'(active_reg) + NUM_W'(1))
    // A word that moves on always shows up on the output in the next cycle.
    `SLPC_ASSERT_NEXT(a_advance_out, aclk, aresetn, advance, m_valid)
    // A byte waiting in the input register is neither lost nor overwritten.
    `SLPC_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(rx_reg))
    // A level never exceeds full scale.
    `SLPC_ASSERT_SAME(a_level_max, aclk, aresetn, m_valid,
        m_green_level <= LEVEL_MAX && m_yellow_level <= LEVEL_MAX && m_red_level <= LEVEL_MAX)

endmodule

`default_nettype wire

// File: sim/tb_serial_led_preset_controller_core.sv
// ----------------------------------------------------------------------------
// tb_serial_led_preset_controller_core
// Feeds command bytes to the LED preset controller and checks every result
// word against a cycle-free model of the mode machine, the preset table and
// the channel levels. A short directed sequence covers the command set and
// its corner cases, then random configuration sessions, preset selections
// and noise bytes follow, with random gaps on the sender and stalls on the
// receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_serial_led_preset_controller_core;

    import slpc_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEFAULT;
    localparam int LEVEL_SCALE  = 10;
    localparam int RANDOM_BYTES = 800;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] yellow;
        logic [LEVEL_W-1:0] red;
        logic [MSG_W-1:0]   message;
        logic [NUM_W-1:0]   number;
        logic [MODE_W-1:0]  mode;
    } led_word_t;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_COIN,
        PACE_THREE_OF_FOUR,
        PACE_SPARSE
    } rx_pace_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic [DATA_W-1:0]   s_rx_byte = '0;
    logic                m_ready   = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [LEVEL_W-1:0]  m_green_level;
    logic [LEVEL_W-1:0]  m_yellow_level;
    logic [LEVEL_W-1:0]  m_red_level;
    logic [MSG_W-1:0]    m_message;
    logic [NUM_W-1:0]    m_number;
    logic [MODE_W-1:0]   m_mode_now;

    logic [DATA_W-1:0]   cmd_bytes[$];
    led_word_t           expected_words[$];
    int                  err_cnt = 0;
    int                  accepted_cnt = 0;

    // Model state of the controller.
    logic [MODE_W-1:0]   mode_q;
    logic [COLOR_W-1:0]  slot_color[SLOTS];
    logic [DUTY_W-1:0]   slot_duty[SLOTS];
    int                  cfg_slot;
    logic [LEVEL_W-1:0]  lvl_green;
    logic [LEVEL_W-1:0]  lvl_yellow;
    logic [LEVEL_W-1:0]  lvl_red;

    serial_led_preset_controller_core #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_green_level (m_green_level),
        .m_yellow_level(m_yellow_level),
        .m_red_level   (m_red_level),
        .m_message     (m_message),
        .m_number      (m_number),
        .m_mode_now    (m_mode_now)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Clears all channels, then lights the channel of the slot's color.
    function automatic void light_slot(input int s);
        logic [LEVEL_W-1:0] level;
        lvl_green  = '0;
        lvl_yellow = '0;
        lvl_red    = '0;
        if (slot_duty[s] > DUTY_MAX) begin
            level = LEVEL_MAX;
        end else begin
            level = LEVEL_W'(int'(slot_duty[s]) * LEVEL_SCALE);
        end
        case (slot_color[s])
            COLOR_GREEN:  lvl_green  = level;
            COLOR_YELLOW: lvl_yellow = level;
            COLOR_RED:    lvl_red    = level;
            default:      ;
        endcase
    endfunction

    function automatic void restore_factory();
        mode_q = MODE_CODE_WORK;
        for (int i = 0; i < SLOTS; i++) begin
            slot_color[i] = (i % 9 < 3) ? COLOR_GREEN : (i % 9 < 6) ? COLOR_YELLOW : COLOR_RED;
            slot_duty[i]  = (i % 3 == 0) ? 7'd10 : (i % 3 == 1) ? 7'd40 : 7'd100;
        end
        cfg_slot = 0;
        light_slot(0);
    endfunction

    // Advances the model by one command byte and queues the word it produces.
    function automatic void interpret_byte(input logic [DATA_W-1:0] c);
        led_word_t         w;
        int                slot;
        logic [DUTY_W-1:0] d;
        w.number = '0;
        slot = (c >= CHAR_ONE && int'(c) < int'(CHAR_ONE) + SLOTS) ? int'(c - CHAR_ONE) : -1;
        if (mode_q == MODE_CODE_WORK) begin
            if (c == CHAR_ZERO) begin
                lvl_green  = '0;
                lvl_yellow = '0;
                lvl_red    = '0;
                w.message  = MSG_OFF;
            end else if (slot >= 0) begin
                light_slot(slot);
                w.message = MSG_PRESET;
                w.number  = NUM_W'(slot + 1);
            end else if (c == CHAR_CR) begin
                mode_q    = MODE_CODE_SLOT;
                w.message = MSG_CONFIG;
            end else begin
                w.message = MSG_UNKNOWN;
            end
        end else if (mode_q == MODE_CODE_SLOT && slot >= 0) begin
            cfg_slot = slot;
            light_slot(slot);
            mode_q    = MODE_CODE_COLOR;
            w.message = MSG_PICK_COLOR;
        end else if (mode_q == MODE_CODE_COLOR && (c == CHAR_A || c == CHAR_B || c == CHAR_C)) begin
            slot_color[cfg_slot] = COLOR_W'(c - CHAR_A);
            light_slot(cfg_slot);
            mode_q    = MODE_CODE_BRIGHT;
            w.message = MSG_ADJUST;
        end else if (mode_q == MODE_CODE_BRIGHT && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            d = slot_duty[cfg_slot];
            if (c == CHAR_PLUS) begin
                d = (d + DUTY_STEP > DUTY_MAX) ? DUTY_MAX : d + DUTY_STEP;
            end else begin
                d = (d < DUTY_STEP) ? '0 : d - DUTY_STEP;
            end
            slot_duty[cfg_slot] = d;
            light_slot(cfg_slot);
            w.message = MSG_BRIGHTNESS;
            w.number  = NUM_W'(d);
        end else if (c == CHAR_CR) begin
            mode_q    = MODE_CODE_WORK;
            w.message = MSG_SAVED;
        end else begin
            w.message = MSG_INVALID;
        end
        w.green  = lvl_green;
        w.yellow = lvl_yellow;
        w.red    = lvl_red;
        w.mode   = mode_q;
        expected_words.push_back(w);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
                $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid      <= 1'b0;
            accepted_cnt <= 0;
            restore_factory();
            burst_left = $urandom_range(1, 20);
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                interpret_byte(s_rx_byte);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (cmd_bytes.size() > 0) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= cmd_bytes.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the pacing is redrawn at random, plus one long hold-off
    // while the sender keeps offering words, so the block backs up.
    rx_pace_t pace;
    int       pace_left;
    int       pace_phase;
    int       hold_left;
    bit       hold_done;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            pace       = PACE_FULL;
            pace_left  = 0;
            pace_phase = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            if (pace_left == 0) begin
                pace      = rx_pace_t'($urandom_range(0, 3));
                pace_left = $urandom_range(16, 96);
            end else begin
                pace_left--;
            end
            pace_phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                case (pace)
                    PACE_FULL:          m_ready <= 1'b1;
                    PACE_COIN:          m_ready <= 1'($urandom_range(0, 1));
                    PACE_THREE_OF_FOUR: m_ready <= (pace_phase % 4 != 0);
                    default:            m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor.
    led_word_t want_word;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("[%0t] result word with nothing expected: message %0d",
                             $realtime, m_message);
                end
            end else begin
                want_word = expected_words.pop_front();
                check_field("green_level", 32'(want_word.green), 32'(m_green_level));
                check_field("yellow_level", 32'(want_word.yellow), 32'(m_yellow_level));
                check_field("red_level", 32'(want_word.red), 32'(m_red_level));
                check_field("message", 32'(want_word.message), 32'(m_message));
                check_field("number", 32'(want_word.number), 32'(m_number));
                check_field("mode_now", 32'(want_word.mode), 32'(m_mode_now));
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int directed;
        int pick;
        int steps;

        // Work mode from reset: unknown bytes at both ends of the range,
        // all off, first and last slot, a digit past the slot count.
        cmd_bytes = '{8'h00, 8'hFF, CHAR_ZERO, CHAR_ONE, 8'h39, 8'h3A, CHAR_A,
                      // Slot selection: a digit past the slot count is invalid,
                      // then save straight out of slot selection.
                      CHAR_CR, 8'h3A, CHAR_CR,
                      // Invalid byte while picking a color, save from there.
                      CHAR_CR, CHAR_ONE, 8'h64, CHAR_CR,
                      // Slot 1 at 10 percent: step down past zero and back up.
                      CHAR_CR, CHAR_ONE, CHAR_B, CHAR_MINUS, CHAR_MINUS, CHAR_PLUS,
                      CHAR_ZERO, CHAR_CR,
                      // Slot 3 at 100 percent saturates at the top.
                      CHAR_CR, 8'h33, CHAR_C, CHAR_PLUS, CHAR_CR, 8'h33};
        directed = cmd_bytes.size();

        while (cmd_bytes.size() < directed + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                cmd_bytes.push_back(DATA_W'(CHAR_ONE + $urandom_range(0, SLOTS - 1)));
            end else if (pick < 20) begin
                cmd_bytes.push_back(CHAR_ZERO);
            end else if (pick < 28) begin
                cmd_bytes.push_back(DATA_W'($urandom_range(0, 255)));
            end else begin
                // A configuration session, now and then broken by noise.
                cmd_bytes.push_back(CHAR_CR);
                if ($urandom_range(0, 9) == 0) begin
                    cmd_bytes.push_back(DATA_W'($urandom_range(0, 255)));
                end
                cmd_bytes.push_back(DATA_W'(CHAR_ONE + $urandom_range(0, SLOTS - 1)));
                if ($urandom_range(0, 9) == 0) begin
                    cmd_bytes.push_back(DATA_W'($urandom_range(0, 255)));
                end
                cmd_bytes.push_back(DATA_W'(CHAR_A + $urandom_range(0, 2)));
                steps = $urandom_range(0, 12);
                for (int i = 0; i < steps; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        cmd_bytes.push_back(DATA_W'($urandom_range(0, 255)));
                    end
                    cmd_bytes.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                end
                cmd_bytes.push_back(CHAR_CR);
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
